// ===== rtl/fwt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fwt_pkg;

	localparam int SUM_W   = 64;
	localparam int DELTA_W = 32;
	localparam int POS_W   = 10;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_QHI,
		ST_QLO,
		ST_RESP
	} fwt_state_t;

	// Controls from the sequencer to the datapath and the node store.
	typedef struct packed {
		logic in_load;
		logic rd_en;
		logic wr_en;
		logic wr_zero;
		logic acc_clr;
		logic acc_en;
		logic acc_sub;
		logic out_load;
	} fwt_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/fwt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fwt_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/fwt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fwt_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fwt_pkg::fwt_ctrl_t                   ctrl,
	input  logic signed [fwt_pkg::DELTA_W-1:0]   delta,
	input  logic [fwt_pkg::SUM_W-1:0]            rd_data,
	output logic [fwt_pkg::SUM_W-1:0]            wr_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [fwt_pkg::SUM_W-1:0]            out_sum,
	output logic                                 out_busy
);

	import fwt_pkg::*;

	logic signed [DELTA_W-1:0] delta_q;
	logic [SUM_W-1:0] delta_ext;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] op_a;
	logic [SUM_W-1:0] op_b;
	logic [SUM_W-1:0] sum;
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;

	assign delta_ext = {{(SUM_W - DELTA_W){delta_q[DELTA_W-1]}}, delta_q};

	// One adder serves both the node update and the query accumulation.
	always_comb begin
		op_a = ctrl.acc_en ? acc_q : rd_data;
		op_b = ctrl.acc_en ? rd_data : delta_ext;
		sum  = op_a + (ctrl.acc_sub ? ~op_b : op_b) + {{(SUM_W - 1){1'b0}}, ctrl.acc_sub};
	end

	assign wr_data = ctrl.wr_zero ? '0 : sum;

	always_ff @(posedge clk) begin
		if (ctrl.in_load) begin
			delta_q <= delta;
		end
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= sum;
		end
		if (ctrl.out_load) begin
			out_sum_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;
	assign out_busy  = out_valid_q && !out_ready;

endmodule

`default_nettype wire

// ===== rtl/fwt_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fwt_seq #(
	parameter int INDEX_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [fwt_pkg::POS_W-1:0]   position,
	input  logic [fwt_pkg::POS_W-1:0]   range_low,
	input  logic [fwt_pkg::POS_W-1:0]   range_high,
	input  logic                        out_busy,
	output fwt_pkg::fwt_ctrl_t          ctrl,
	output logic [INDEX_BITS-1:0]       rd_addr,
	output logic [INDEX_BITS-1:0]       wr_addr
);

	import fwt_pkg::*;

	localparam int NB = INDEX_BITS + 1;
	localparam logic [NB-1:0] NODE_ONE   = {{INDEX_BITS{1'b0}}, 1'b1};
	localparam logic [NB-1:0] NODE_COUNT = {1'b1, {INDEX_BITS{1'b0}}};
	localparam logic [INDEX_BITS-1:0] CLR_LAST = {INDEX_BITS{1'b1}};

	fwt_state_t state_q;
	fwt_state_t state_d;

	logic [NB-1:0]         node_q;
	logic [INDEX_BITS-1:0] lo_q;
	logic [INDEX_BITS-1:0] clr_q;
	logic                  pend_q;
	logic [INDEX_BITS-1:0] pend_addr_q;

	logic [NB-1:0]         low_bit;
	logic [NB-1:0]         node_m1;
	logic [INDEX_BITS-1:0] node_addr;
	logic [INDEX_BITS-1:0] pos_idx;
	logic [INDEX_BITS-1:0] lo_idx;
	logic [INDEX_BITS-1:0] hi_idx;
	logic                  node_ok;
	logic                  walking;
	logic                  issue;
	logic                  phase_done;
	logic                  accept;

	assign pos_idx = INDEX_BITS'(position);
	assign lo_idx  = INDEX_BITS'(range_low);
	assign hi_idx  = INDEX_BITS'(range_high);

	assign low_bit   = node_q & (~node_q + NODE_ONE);
	assign node_m1   = node_q - NODE_ONE;
	assign node_addr = node_m1[INDEX_BITS-1:0];
	// An upward step past the top wraps to zero, which also ends the walk.
	assign node_ok   = (node_q != '0) && (node_q <= NODE_COUNT);

	assign walking    = (state_q == ST_UPDATE) || (state_q == ST_QHI) || (state_q == ST_QLO);
	assign issue      = walking && node_ok;
	assign phase_done = walking && !node_ok && !pend_q;
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (func == FUNC_QUERY) ? ST_QHI : ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (phase_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_QHI: begin
				if (phase_done) begin
					state_d = ST_QLO;
				end
			end
			ST_QLO: begin
				if (phase_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		ctrl          = '0;
		ctrl.in_load  = accept;
		ctrl.acc_clr  = accept;
		ctrl.rd_en    = issue;
		ctrl.wr_en    = (state_q == ST_CLEAR) || ((state_q == ST_UPDATE) && pend_q);
		ctrl.wr_zero  = (state_q == ST_CLEAR);
		ctrl.acc_en   = pend_q && ((state_q == ST_QHI) || (state_q == ST_QLO));
		ctrl.acc_sub  = (state_q == ST_QLO);
		ctrl.out_load = (state_q == ST_RESP) && !out_busy;
		rd_addr       = node_addr;
		wr_addr       = (state_q == ST_CLEAR) ? clr_q : pend_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + {{(INDEX_BITS - 1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pend_addr_q <= node_addr;
		end
		if (accept) begin
			lo_q <= lo_idx;
			if (func == FUNC_QUERY) begin
				node_q <= {1'b0, hi_idx} + NODE_ONE;
			end else begin
				node_q <= {1'b0, pos_idx} + NODE_ONE;
			end
		end else if (issue) begin
			if (state_q == ST_UPDATE) begin
				node_q <= node_q + low_bit;
			end else begin
				node_q <= node_q - low_bit;
			end
		end else if ((state_q == ST_QHI) && phase_done) begin
			node_q <= {1'b0, lo_q};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fenwick_tree_range_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fenwick tree over 2^INDEX_BITS positions with point updates and range-sum
// queries, all sums wrapping at 64 bits. After reset the node store is swept
// to zero while s_tready stays low. The block then takes one item at a time:
// an update walks n tree nodes, and a query walks n1 nodes for the range_high
// prefix and n2 nodes for the prefix below range_low (n2 is zero when
// range_low is zero). An update visits at most INDEX_BITS + 1 nodes and each
// prefix of a query at most INDEX_BITS. The walk is paced by the single read
// port of the node store, which delivers one node per cycle to one shared
// 64-bit adder. A finished sum waits in the output register while the next
// item is accepted; a query that finishes before the previous sum has been
// taken holds for every further cycle that sum stays untaken.
module fenwick_tree_range_sum #(
	parameter int INDEX_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // position[9:0], delta[41:10], range_low[51:42],
	                              // range_high[61:52], zero[63:62]
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // range_sum[63:0]
);

	import fwt_pkg::*;

	fwt_ctrl_t             ctrl;
	logic [INDEX_BITS-1:0] rd_addr;
	logic [INDEX_BITS-1:0] wr_addr;
	logic [SUM_W-1:0]      rd_data;
	logic [SUM_W-1:0]      wr_data;
	logic                  out_busy;

	fwt_seq #(
		.INDEX_BITS(INDEX_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.func       (s_tuser),
		.position   (s_tdata[9:0]),
		.range_low  (s_tdata[51:42]),
		.range_high (s_tdata[61:52]),
		.out_busy   (out_busy),
		.ctrl       (ctrl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr)
	);

	fwt_ram #(
		.ADDR_W(INDEX_BITS),
		.DATA_W(SUM_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ctrl.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctrl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	fwt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.delta     (s_tdata[41:10]),
		.rd_data   (rd_data),
		.wr_data   (wr_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_sum   (m_tdata),
		.out_busy  (out_busy)
	);

	// A result is only loaded when the output register is free to take it.
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over an untaken result");

	// The block is busy in the cycle after each accepted item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// An update write always follows the read of the same node.
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wr_en && !ctrl.wr_zero) |-> $past(ctrl.rd_en))
		else $error("node written without a preceding read");

	// Accumulation consumes read data fetched in the previous cycle.
	a_acc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.acc_en |-> ($past(ctrl.rd_en) && !ctrl.wr_en))
		else $error("accumulation without read data");

endmodule

`default_nettype wire
